/* design/krbh_pkg.sv */
// ----------------------------------------------------------------------------
// krbh_pkg: shared definitions for the keyed rolling byte hash
// Sizes, register map, seed index table and the structs that pass between
// the configuration registers, the hash core and the top level.
// ----------------------------------------------------------------------------
package krbh_pkg;

    localparam int KEY_LENGTH        = 12;
    localparam int MAX_MESSAGE_BYTES = 512;
    localparam int SECRET_MAX        = 16;

    localparam int KP_W  = $clog2(KEY_LENGTH);
    localparam int IDX_W = $clog2(MAX_MESSAGE_BYTES + 1);

    localparam logic [7:0] SEED_OFFSET = 8'h5A;

    // register indexes (paddr[4:3])
    localparam logic [1:0] REG_SECRET_LOW    = 2'd0;
    localparam logic [1:0] REG_SECRET_HIGH   = 2'd1;
    localparam logic [1:0] REG_SECRET_LENGTH = 2'd2;

    typedef struct packed {
        logic [63:0] secret_low;
        logic [63:0] secret_high;
        logic [4:0]  secret_length;
    } krbh_cfg_t;

    typedef struct packed {
        logic [31:0] key_high;
        logic [63:0] key_low;
        logic [9:0]  bytes_absorbed;
        logic        truncated;
    } krbh_result_t;

    // secret byte index used by seed byte i for effective length n (n-1 as column)
    typedef logic [KEY_LENGTH-1:0][SECRET_MAX-1:0][3:0] seed_sel_t;

    function automatic seed_sel_t build_seed_sel();
        seed_sel_t t;
        int        idx;
        t = '0;
        for (int n = 1; n <= SECRET_MAX; n++)
        begin
            idx = 0;
            for (int i = 0; i < KEY_LENGTH; i++)
            begin
                t[i][n-1] = 4'(idx);
                if (idx + 1 >= n)
                    idx = 0;
                else
                    idx = idx + 1;
            end
        end
        return t;
    endfunction

    localparam seed_sel_t SEED_SEL = build_seed_sel();

    // zero acts as one, saturate at the secret size
    function automatic logic [4:0] eff_len(input logic [4:0] len);
        logic [4:0] n;
        n = len;
        if (n == 5'd0)
            n = 5'd1;
        if (n > 5'(SECRET_MAX))
            n = 5'(SECRET_MAX);
        return n;
    endfunction

endpackage

/* design/krbh_cfg.sv */
// ----------------------------------------------------------------------------
// krbh_cfg: configuration registers
// APB-style register file holding the secret and its length.
// ----------------------------------------------------------------------------
module krbh_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    output krbh_pkg::krbh_cfg_t cfg
);
    import krbh_pkg::*;

    logic [63:0] secret_low_reg;
    logic [63:0] secret_high_reg;
    logic [4:0]  secret_length_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            secret_low_reg    <= '0;
            secret_high_reg   <= '0;
            secret_length_reg <= 5'(SECRET_MAX);
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_SECRET_LOW:    secret_low_reg    <= pwdata;
                REG_SECRET_HIGH:   secret_high_reg   <= pwdata;
                REG_SECRET_LENGTH: secret_length_reg <= pwdata[4:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SECRET_LOW:    prdata = secret_low_reg;
            REG_SECRET_HIGH:   prdata = secret_high_reg;
            REG_SECRET_LENGTH: prdata = {59'd0, secret_length_reg};
            default:           prdata = '0;
        endcase
    end

    assign cfg.secret_low    = secret_low_reg;
    assign cfg.secret_high   = secret_high_reg;
    assign cfg.secret_length = secret_length_reg;

endmodule

/* design/krbh_core.sv */
// ----------------------------------------------------------------------------
// krbh_core: hash state and combinational absorb step
// Holds the keyed state; folds in each accepted byte, up to 512 per message.
// ----------------------------------------------------------------------------
module krbh_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  krbh_pkg::krbh_cfg_t    cfg,
    input  logic                   in_fire,
    input  logic [7:0]             data_byte,
    input  logic                   has_byte,
    input  logic                   last,
    output krbh_pkg::krbh_result_t result
);
    import krbh_pkg::*;

    logic [KEY_LENGTH-1:0][7:0] hash_reg,  hash_next;
    logic [7:0]                 carry_reg, carry_next;
    logic [KP_W-1:0]            kpos_reg,  kpos_next;
    logic [3:0]                 spos_reg,  spos_next;
    logic [IDX_W-1:0]           idx_reg,   idx_next;
    logic                       ovf_reg,   ovf_next;
    logic                       start_reg, start_next;

    logic [SECRET_MAX-1:0][7:0] secret;
    logic [4:0]                 n_len;
    logic [KEY_LENGTH-1:0][7:0] seed_bytes;
    logic [KEY_LENGTH-1:0][7:0] cur_hash;
    logic [7:0]                 cur_carry;
    logic [KP_W-1:0]            cur_kpos;
    logic [3:0]                 cur_spos;
    logic [IDX_W-1:0]           cur_idx;
    logic                       cur_ovf;
    logic [3:0]                 sp;
    logic [7:0]                 k;
    logic [7:0]                 mix;
    logic [7:0]                 v;
    logic [KP_W:0]              q_sum;
    logic [KP_W-1:0]            q;
    logic                       absorb;
    logic [IDX_W+9:0]           idx_ext;
    logic [63:0]                lo;

    assign secret = {cfg.secret_high, cfg.secret_low};
    assign n_len  = eff_len(cfg.secret_length);

    always_comb
    begin
        for (int i = 0; i < KEY_LENGTH; i++)
            seed_bytes[i] = secret[SEED_SEL[i][n_len[3:0] - 4'd1]] + SEED_OFFSET;
    end

    // reseed at the first transaction of a message
    assign cur_hash  = start_reg ? seed_bytes : hash_reg;
    assign cur_carry = start_reg ? 8'd0 : carry_reg;
    assign cur_kpos  = start_reg ? '0 : kpos_reg;
    assign cur_spos  = start_reg ? 4'd0 : spos_reg;
    assign cur_idx   = start_reg ? '0 : idx_reg;
    assign cur_ovf   = start_reg ? 1'b0 : ovf_reg;

    assign absorb = has_byte && (cur_idx < IDX_W'(MAX_MESSAGE_BYTES));

    assign sp    = ({1'b0, cur_spos} >= n_len) ? 4'd0 : cur_spos;
    assign k     = secret[sp];
    assign mix   = (cur_hash[cur_kpos] ^ data_byte) + k + cur_carry;
    assign v     = {mix[4:0], mix[7:5]};
    assign q_sum = {1'b0, cur_kpos} + (KP_W+1)'(5);
    assign q     = (q_sum >= (KP_W+1)'(KEY_LENGTH)) ?
                   KP_W'(q_sum - (KP_W+1)'(KEY_LENGTH)) : q_sum[KP_W-1:0];

    always_comb
    begin
        hash_next  = cur_hash;
        carry_next = cur_carry;
        kpos_next  = cur_kpos;
        spos_next  = cur_spos;
        idx_next   = cur_idx;
        ovf_next   = cur_ovf;
        if (absorb)
        begin
            for (int j = 0; j < KEY_LENGTH; j++)
            begin
                if (KP_W'(j) == cur_kpos)
                    hash_next[j] = v;
                if (KP_W'(j) == q)
                    hash_next[j] = cur_hash[j] ^ (v + cur_idx[7:0]);
            end
            carry_next = cur_carry + v + k;
            kpos_next  = (cur_kpos == KP_W'(KEY_LENGTH - 1)) ? '0 : cur_kpos + 1'b1;
            spos_next  = ({1'b0, sp} + 5'd1 >= n_len) ? 4'd0 : sp + 4'd1;
            idx_next   = cur_idx + 1'b1;
        end
        else if (has_byte)
        begin
            ovf_next = 1'b1;
        end
        start_next = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg  <= '0;
            carry_reg <= '0;
            kpos_reg  <= '0;
            spos_reg  <= '0;
            idx_reg   <= '0;
            ovf_reg   <= 1'b0;
            start_reg <= 1'b1;
        end
        else if (in_fire)
        begin
            hash_reg  <= hash_next;
            carry_reg <= carry_next;
            kpos_reg  <= kpos_next;
            spos_reg  <= spos_next;
            idx_reg   <= idx_next;
            ovf_reg   <= ovf_next;
            start_reg <= start_next;
        end
    end

    // pack the key from the updated state
    always_comb
    begin
        lo = '0;
        for (int j = 4; j < KEY_LENGTH; j++)
            lo = {lo[55:0], hash_next[j]};
    end

    assign idx_ext = {10'd0, idx_next};

    assign result.key_high       = {hash_next[0], hash_next[1], hash_next[2], hash_next[3]};
    assign result.key_low        = lo;
    assign result.bytes_absorbed = idx_ext[9:0];
    assign result.truncated      = ovf_next;

`ifndef ASSERT_OFF
    a_kpos_range: assert property (@(posedge clk) disable iff (!rst_n)
        kpos_reg < KP_W'(KEY_LENGTH))
        else $error("key position out of range");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_W'(MAX_MESSAGE_BYTES))
        else $error("byte index past message limit");

    a_ovf_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> idx_reg == IDX_W'(MAX_MESSAGE_BYTES))
        else $error("overflow flagged below message limit");

    a_reseed_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && last) |=> start_reg)
        else $error("no reseed after closing transaction");
`endif

endmodule

/* design/keyed_rolling_byte_hash_top.sv */
// ----------------------------------------------------------------------------
// keyed_rolling_byte_hash_top: keyed rolling byte hash, stream in, key out
// Absorbs a byte per transaction with s_tuser set; emits the key on tlast.
// ----------------------------------------------------------------------------
// The block takes one byte transaction per clock cycle, back to back, and
// emits one key transaction in the cycle after the transaction that carries
// tlast. The rate is set by the absorb step in krbh_core: the whole fold of
// a byte (xor, two adds, rotate, third add, second xor) sits between the
// state registers, so a new byte enters every cycle. The result register in
// this level holds the key until it is taken. While it holds an unread key
// and m_tready is low, s_tready is low and every input transaction waits,
// closing or not; while m_tready is high the input runs at full rate, as the
// waiting key drains in the same cycle that a new one may load. The
// state is seeded from the secret at the first transaction of each message,
// using the registers as they then stand; no clearing pass after reset.
// Bytes beyond 512 in one message are dropped and flagged in the result.
// ----------------------------------------------------------------------------
module keyed_rolling_byte_hash_top (
    input  logic          clk,
    input  logic          rst_n,
    // byte input
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] data_byte
    input  logic          s_tuser,   // [0] has_byte
    input  logic          s_tlast,   // last
    // key output
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [111:0]  m_tdata,   // [31:0] key_high, [95:32] key_low,
                                     // [105:96] bytes_absorbed, [106] truncated,
                                     // [111:107] zero
    // configuration
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);
    import krbh_pkg::*;

    krbh_cfg_t    cfg;
    krbh_result_t core_result;
    krbh_result_t out_reg,   out_next;
    logic         out_valid_reg, out_valid_next;
    logic         in_fire;
    logic         load;

    krbh_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    krbh_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_fire   (in_fire),
        .data_byte (s_tdata),
        .has_byte  (s_tuser),
        .last      (s_tlast),
        .result    (core_result)
    );

    // accept while the result register is free or being drained this cycle
    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;
    assign load     = in_fire && s_tlast;

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_next       = core_result;
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            // drop the key once its transaction completes
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload holds without reset
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.truncated, out_reg.bytes_absorbed,
                       out_reg.key_low, out_reg.key_high};

`ifndef ASSERT_OFF
    a_key_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> m_tvalid)
        else $error("closing transaction produced no key");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (out_valid_reg && !m_tready))
        else $error("input stalled with result register free");

    a_key_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("waiting key changed before it was taken");
`endif

endmodule
